>>> rtl/core/gb5_pkg.sv
// ----------------------------------------------------------------------------
// gb5_pkg: shared types and constants for the 5x5 Gaussian blur core
// Register indexes, field widths and the front-to-back job record.
// ----------------------------------------------------------------------------
`default_nettype none
package gb5_pkg;
  localparam int KSIZE     = 5;
  localparam int SLOTS     = KSIZE - 1;
  localparam int HALF      = (KSIZE - 1) / 2;
  localparam int MAXW      = 1024;
  localparam int MAXH      = 4096;
  localparam int COLW      = 10;
  localparam int ROWW      = 12;
  localparam int LSDEPTH   = SLOTS * MAXW;
  localparam int LSAW      = $clog2(LSDEPTH);
  localparam int SLOTW     = 2;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_TAP0   = 3'd2;
  localparam logic [2:0] REG_TAP1   = 3'd3;
  localparam logic [2:0] REG_TAP2   = 3'd4;
  localparam logic [2:0] REG_TAP3   = 3'd5;

  typedef logic [7:0] pix_t;

  typedef struct packed {
    pix_t [KSIZE-1:0] col;
    logic [ROWW-1:0]  row;
    logic [COLW-1:0]  column;
    logic             emit;
    logic             last;
  } job_t;
endpackage
`default_nettype wire

>>> rtl/core/gb5_ram.sv
// ----------------------------------------------------------------------------
// gb5_ram: generic simple dual-port RAM with registered read
// One write and one read address per cycle; read data valid the cycle after.
// ----------------------------------------------------------------------------
`default_nettype none
module gb5_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/gb5_front.sv
// ----------------------------------------------------------------------------
// gb5_front: raster position tracking and line store access
// Reads the four stored rows of the column, writes the new pixel over
// the oldest, and hands a column job to the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module gb5_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic [7:0]           in_pixel,
  input  wire logic [10:0]          width_cfg,
  input  wire logic [12:0]          height_cfg,
  input  wire logic                 q_ready,
  output logic                      q_valid,
  output gb5_pkg::job_t             q_job
);
  import gb5_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_HAND} state_t;

  state_t           state_r;
  logic [2:0]       slot_r;
  logic [ROWW-1:0]  row_r;
  logic [COLW:0]    colc_r;
  logic [ROWW-1:0]  r_r;
  logic [COLW-1:0]  c_r;
  logic             last_r;
  pix_t             pix_r;
  pix_t [SLOTS-1:0] got_r;
  logic [12:0]      w_eff;
  logic [13:0]      h_eff;
  logic [COLW:0]    colc_a;
  logic [ROWW:0]    row_a;
  logic [ROWW:0]    row_b;
  logic [SLOTW-1:0] rslot;
  logic [SLOTW-1:0] wslot;
  logic             re;
  logic             we;
  logic [LSAW-1:0]  raddr;
  logic [LSAW-1:0]  waddr;
  pix_t             rdata;
  logic [COLW:0]    colc_nxt;
  logic [ROWW:0]    row_nxt;
  logic [2:0]       slot_d;

  always_comb begin
    w_eff = {2'b00, width_cfg};
    if (width_cfg < 11'(KSIZE)) w_eff = 13'(KSIZE);
    if (width_cfg > 11'(MAXW)) w_eff = 13'(MAXW);
    h_eff = {1'b0, height_cfg};
    if (height_cfg < 13'(KSIZE)) h_eff = 14'(KSIZE);
    // 13 bits can reach 8191, above MAXH; clamp to MAXH
    if ({1'b0, height_cfg} > 14'(MAXH)) h_eff = 14'(MAXH);
  end

  always_comb begin
    colc_a = colc_r;
    row_a  = {1'b0, row_r};
    if (13'(colc_r) >= w_eff) begin
      colc_a = '0;
      row_a  = row_a + 1'b1;
    end
    if (14'(row_a) >= h_eff) row_a = '0;
    colc_nxt = colc_a + 1'b1;
    row_nxt  = row_a;
    if (13'(colc_nxt) >= w_eff) begin
      colc_nxt = '0;
      row_nxt  = row_a + 1'b1;
      if (14'(row_nxt) >= h_eff) row_nxt = '0;
    end
    row_b = row_a;
  end

  always_comb begin
    slot_d = 3'(({1'b0, r_r[SLOTW-1:0]}) + slot_r);
    rslot  = slot_d[SLOTW-1:0];
    wslot  = r_r[SLOTW-1:0];
    re     = (state_r == S_READ) && (slot_r < 3'(SLOTS));
    we     = (state_r == S_READ) && (slot_r == 3'(SLOTS));
    raddr  = {rslot, c_r};
    waddr  = {wslot, c_r};
  end

  gb5_ram #(.WIDTH(8), .DEPTH(LSDEPTH)) u_ls (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(pix_r),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r  <= '0;
      row_r   <= '0;
      colc_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_push) begin
            pix_r   <= in_pixel;
            r_r     <= row_b[ROWW-1:0];
            c_r     <= colc_a[COLW-1:0];
            last_r  <= (14'(row_b) == h_eff - 1'b1) && (13'(colc_a) == w_eff - 1'b1);
            row_r   <= row_nxt[ROWW-1:0];
            colc_r  <= colc_nxt;
            slot_r  <= '0;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          if (slot_r != 3'd0) got_r[2'(slot_r - 3'd1)] <= rdata;
          slot_r <= slot_r + 1'b1;
          if (slot_r == 3'(SLOTS)) state_r <= S_HAND;
        end
        S_HAND: begin
          if (q_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_full        = (state_r != S_IDLE);
    q_valid        = (state_r == S_HAND);
    q_job.col      = {pix_r, got_r[3], got_r[2], got_r[1], got_r[0]};
    q_job.row      = r_r - ROWW'(HALF);
    q_job.column   = c_r - COLW'(HALF);
    q_job.emit     = (r_r >= ROWW'(SLOTS)) && (c_r >= COLW'(SLOTS));
    q_job.last     = last_r;
  end
endmodule
`default_nettype wire

>>> rtl/core/gb5_queue.sv
// ----------------------------------------------------------------------------
// gb5_queue: two-entry job queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module gb5_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  gb5_pkg::job_t      wr_job,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output gb5_pkg::job_t      rd_job
);
  import gb5_pkg::*;

  job_t       ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       wr;
  logic       rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job   = ent_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) ent_r[wp_r] <= wr_job;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/gb5_back.sv
// ----------------------------------------------------------------------------
// gb5_back: window shift and weighted sum
// Shifts each column into the window; for interior centres runs a
// multiply-accumulate over the 25 taps, one tap at a time, then
// rounds, saturates and places the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module gb5_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  gb5_pkg::job_t      q_job,
  input  wire logic [15:0]   tap0,
  input  wire logic [15:0]   tap1,
  input  wire logic [15:0]   tap2,
  output logic               out_empty,
  input  wire logic          out_pop,
  output logic [7:0]         out_blurred,
  output logic [11:0]        out_row,
  output logic [9:0]         out_column,
  output logic               out_frame_end
);
  import gb5_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ACC, S_DONE} state_t;

  state_t                      state_r;
  pix_t [KSIZE-1:0][KSIZE-1:0] win_r;
  logic [2:0]                  i_r;
  logic [2:0]                  j_r;
  logic [31:0]                 wt_r;
  pix_t                        px_r;
  logic [63:0]                 acc_r;
  logic [ROWW-1:0]             row_r;
  logic [COLW-1:0]             col_r;
  logic                        last_r;
  logic                        full_r;
  logic [2:0]                  di;
  logic [2:0]                  dj;
  logic [15:0]                 wi;
  logic [15:0]                 wj;
  logic [39:0]                 prod;
  logic [32:0]                 res;
  logic                        take;

  function automatic logic [15:0] tap_sel(input logic [2:0] d, input logic [15:0] t0,
                                          input logic [15:0] t1, input logic [15:0] t2);
    logic [15:0] v;
    unique case (d)
      3'd0:    v = t0;
      3'd1:    v = t1;
      default: v = t2;
    endcase
    return v;
  endfunction

  always_comb begin
    di   = (i_r >= 3'(HALF)) ? i_r - 3'(HALF) : 3'(HALF) - i_r;
    dj   = (j_r >= 3'(HALF)) ? j_r - 3'(HALF) : 3'(HALF) - j_r;
    wi   = tap_sel(di, tap0, tap1, tap2);
    wj   = tap_sel(dj, tap0, tap1, tap2);
    prod = wt_r * px_r;
    res  = acc_r[63:31] + 33'd1;
    take = q_valid && (state_r == S_IDLE) && !(q_job.emit && full_r);
    q_ready = take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      full_r  <= 1'b0;
      win_r   <= '0;
    end else begin
      if (out_pop && full_r) full_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            for (int k = 0; k < KSIZE; k++) begin
              win_r[k] <= {q_job.col[k], win_r[k][KSIZE-1:1]};
            end
            row_r  <= q_job.row;
            col_r  <= q_job.column;
            last_r <= q_job.last;
            acc_r  <= '0;
            i_r    <= '0;
            j_r    <= '0;
            if (q_job.emit) state_r <= S_MUL;
          end
        end
        S_MUL: begin
          wt_r    <= wi * wj;
          px_r    <= win_r[i_r][j_r];
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r <= acc_r + 64'(prod);
          if (j_r == 3'(KSIZE - 1)) begin
            j_r <= '0;
            i_r <= i_r + 1'b1;
          end else begin
            j_r <= j_r + 1'b1;
          end
          state_r <= ((i_r == 3'(KSIZE - 1)) && (j_r == 3'(KSIZE - 1))) ? S_DONE : S_MUL;
        end
        S_DONE: begin
          if (!full_r) begin
            out_blurred   <= (res[32:1] > 32'd255) ? 8'd255 : res[8:1];
            out_row       <= row_r;
            out_column    <= col_r;
            out_frame_end <= last_r;
            full_r        <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_empty = !full_r;
endmodule
`default_nettype wire

>>> rtl/core/gaussian_blur_5x5_core.sv
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_core: 5x5 separable Gaussian blur on a raster stream
// ----------------------------------------------------------------------------
// Pixels are pushed in raster order; each interior pixel yields one result
// (value, centre row and column, frame_end on the last one), border pixels
// yield none. The front reads the four stored rows one after another through
// the line store's single read port and takes no new pixel until its job
// is handed to the queue; an interior pixel then goes through the back
// end's multiply-accumulate, one tap at a time. The line store is not
// cleared after reset; reads of unwritten entries only reach border pixels,
// which yield no result.
// ----------------------------------------------------------------------------
`default_nettype none
module gaussian_blur_5x5_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_pixel,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_blurred,
  output logic [11:0]      out_row,
  output logic [9:0]       out_column,
  output logic             out_frame_end,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import gb5_pkg::*;

  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [15:0] tap0_r;
  logic [15:0] tap1_r;
  logic [15:0] tap2_r;
  logic [15:0] tap3_r;
  logic        fq_valid;
  logic        fq_ready;
  job_t        fq_job;
  logic        qb_valid;
  logic        qb_ready;
  job_t        qb_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1024;
      height_r <= 13'd480;
      tap0_r   <= 16'd14583;
      tap1_r   <= 16'd13797;
      tap2_r   <= 16'd11679;
      tap3_r   <= 16'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[10:0];
        REG_HEIGHT: height_r <= cfg_data[12:0];
        REG_TAP0:   tap0_r   <= cfg_data;
        REG_TAP1:   tap1_r   <= cfg_data;
        REG_TAP2:   tap2_r   <= cfg_data;
        REG_TAP3:   tap3_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  gb5_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_pixel(in_pixel), .width_cfg(width_r), .height_cfg(height_r),
    .q_ready(fq_ready), .q_valid(fq_valid), .q_job(fq_job)
  );

  gb5_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(fq_valid), .wr_ready(fq_ready),
    .wr_job(fq_job), .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_job(qb_job)
  );

  gb5_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(qb_valid), .q_ready(qb_ready),
    .q_job(qb_job), .tap0(tap0_r), .tap1(tap1_r),
    .tap2(tap2_r ^ (tap3_r & 16'h0000)),
    .out_empty(out_empty), .out_pop(out_pop), .out_blurred(out_blurred),
    .out_row(out_row), .out_column(out_column), .out_frame_end(out_frame_end)
  );
endmodule
`default_nettype wire

>>> rtl/core/gb5_checker.sv
// ----------------------------------------------------------------------------
// gb5_checker: port-level checks for the blur core
// ----------------------------------------------------------------------------
`default_nettype none
module gb5_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_push,
  input wire logic        in_full,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [7:0]  out_blurred,
  input wire logic [11:0] out_row,
  input wire logic [9:0]  out_column
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_blurred) && $stable(out_row)))
    else $error("waiting result changed");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> in_full)
    else $error("accepted without going busy");
  a_colrange: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_column <= 10'd1021))
    else $error("column out of range");
  a_rst: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result after reset");
endmodule

bind gaussian_blur_5x5_core gb5_checker u_gb5_checker (
  .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
  .out_empty(out_empty), .out_pop(out_pop), .out_blurred(out_blurred),
  .out_row(out_row), .out_column(out_column)
);
`default_nettype wire

>>> tb/sv/tb_gaussian_blur_5x5_core.sv
// ----------------------------------------------------------------------------
// tb_gaussian_blur_5x5_core: self-checking bench for the 5x5 blur core
// ----------------------------------------------------------------------------
// Pushes frames (some cut short) under several frame sizes and tap weights,
// including clamped sizes, saturating and zero weights and ignored register
// writes. A scoreboard class models the line store and window, predicts each
// interior result and checks results in order as they are popped. Both sides
// idle at random. A watchdog ends the run if nothing moves for too long.
// ----------------------------------------------------------------------------
module tb_gaussian_blur_5x5_core;
  timeunit 1ns;
  timeprecision 1ps;
  import gb5_pkg::*;

  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE = 120;

  typedef struct packed {
    logic [7:0]  blurred;
    logic [11:0] row;
    logic [9:0]  column;
    logic        frame_end;
  } blur_res_t;

  class blur_scoreboard;
    logic [7:0]  line_mem [LSDEPTH];
    logic [7:0]  win [KSIZE][KSIZE];
    int unsigned row_cnt, col_cnt;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [15:0] taps [4];
    blur_res_t   pending [$];
    int unsigned n_results;

    function new();
      foreach (line_mem[k]) line_mem[k] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      row_cnt = 0;
      col_cnt = 0;
      width_reg = 11'd1024;
      height_reg = 13'd480;
      taps[0] = 16'd14583;
      taps[1] = 16'd13797;
      taps[2] = 16'd11679;
      taps[3] = 16'd0;
      n_results = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_WIDTH:  width_reg = val[10:0];
        REG_HEIGHT: height_reg = val[12:0];
        REG_TAP0:   taps[0] = val;
        REG_TAP1:   taps[1] = val;
        REG_TAP2:   taps[2] = val;
        REG_TAP3:   taps[3] = val;
        default: ;
      endcase
    endfunction

    function int unsigned eff_w();
      if (width_reg < KSIZE) return KSIZE;
      if (width_reg > MAXW) return MAXW;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg < KSIZE) return KSIZE;
      if (height_reg > MAXH) return MAXH;
      return height_reg;
    endfunction

    function void note_pixel(logic [7:0] px);
      int unsigned w, h, r, c, di, dj;
      logic [7:0]  newcol [KSIZE];
      logic [63:0] acc, sum;
      blur_res_t   res;
      w = eff_w();
      h = eff_h();
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
      end
      if (row_cnt >= h) row_cnt = 0;
      r = row_cnt;
      c = col_cnt % MAXW;
      for (int i = 0; i < SLOTS; i++) newcol[i] = line_mem[((r + i) % SLOTS) * MAXW + c];
      newcol[SLOTS] = px;
      line_mem[(r % SLOTS) * MAXW + c] = px;
      for (int i = 0; i < KSIZE; i++) begin
        for (int j = 0; j < KSIZE - 1; j++) win[i][j] = win[i][j + 1];
        win[i][KSIZE - 1] = newcol[i];
      end
      if (r >= SLOTS && c >= SLOTS) begin
        acc = '0;
        for (int i = 0; i < KSIZE; i++) begin
          di = (i >= HALF) ? i - HALF : HALF - i;
          for (int j = 0; j < KSIZE; j++) begin
            dj = (j >= HALF) ? j - HALF : HALF - j;
            acc += 64'(taps[di]) * 64'(taps[dj]) * 64'(win[i][j]);
          end
        end
        sum = (acc + 64'h8000_0000) >> 32;
        res.blurred = (sum > 255) ? 8'd255 : sum[7:0];
        res.row = 12'(r - HALF);
        res.column = 10'(c - HALF);
        res.frame_end = (r == h - 1 && col_cnt == w - 1);
        pending.push_back(res);
      end
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
        if (row_cnt >= h) row_cnt = 0;
      end
    endfunction

    function string check_result(blur_res_t got);
      blur_res_t want;
      n_results++;
      if (pending.size() == 0)
        return $sformatf("unexpected result %0d/%0d = %0d", got.row, got.column, got.blurred);
      want = pending.pop_front();
      if (got !== want)
        return $sformatf("result %0d: got blurred=%0d row=%0d col=%0d end=%0b, want %0d %0d %0d %0b",
                         n_results, got.blurred, got.row, got.column, got.frame_end,
                         want.blurred, want.row, want.column, want.frame_end);
      return "";
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [7:0] in_pixel = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [7:0] out_blurred;
  logic [11:0] out_row;
  logic [9:0] out_column;
  logic out_frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  blur_scoreboard sb = new();
  int errors = 0;
  int n_pixels = 0;
  int n_frames = 0;
  int stall_cycles = 0;
  bit steady = 1'b0;

  gaussian_blur_5x5_core dut (.*);

  always #2 clk = ~clk;

  task automatic report(input string msg);
    errors++;
    $display("MISMATCH: %s", msg);
  endtask

  always @(negedge clk) out_pop <= steady || ($urandom_range(0, 99) >= 13);

  always @(posedge clk) begin
    string msg;
    if (rst_n && out_pop && !out_empty) begin
      msg = sb.check_result({out_blurred, out_row, out_column, out_frame_end});
      if (msg != "") report(msg);
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready) || !rst_n)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("gaussian_blur_5x5_core verification failed");
      $finish;
    end
  end

  // caller sits at a falling edge
  task automatic push_pixel(input logic [7:0] px);
    while (!steady && $urandom_range(0, 99) < 13) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_pixel(px);
    n_pixels++;
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // pattern: 0 random, 1 all ones, 2 all zeros, 3 checkerboard of extremes
  task automatic send_frame(input int pattern);
    int unsigned w, h;
    logic [7:0] px;
    w = sb.eff_w();
    h = sb.eff_h();
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        case (pattern)
          1: px = 8'hFF;
          2: px = 8'h00;
          3: px = ((r + c) % 2) ? 8'hFF : 8'h00;
          default: px = 8'($urandom_range(0, 255));
        endcase
        push_pixel(px);
      end
    n_frames++;
    drain();
  endtask

  task automatic set_frame(input logic [15:0] w, input logic [15:0] h);
    write_cfg(REG_WIDTH, w);
    write_cfg(REG_HEIGHT, h);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: smallest frame, extremes, clamping, ignored indexes
    set_frame(16'd5, 16'd5);
    send_frame(1);
    send_frame(3);
    write_cfg(REG_SPARE_A, 16'hFFFF);
    write_cfg(REG_SPARE_B, 16'h0000);
    set_frame(16'd0, 16'd0);
    send_frame(2);
    write_cfg(REG_TAP0, 16'hFFFF);
    write_cfg(REG_TAP1, 16'hFFFF);
    write_cfg(REG_TAP2, 16'hFFFF);
    write_cfg(REG_TAP3, 16'hFFFF);
    set_frame(16'd6, 16'd4);
    send_frame(3);
    write_cfg(REG_TAP0, 16'h0000);
    write_cfg(REG_TAP1, 16'h0000);
    write_cfg(REG_TAP2, 16'h0000);
    send_frame(1);
    write_cfg(REG_TAP0, 16'd14583);
    write_cfg(REG_TAP1, 16'd13797);
    write_cfg(REG_TAP2, 16'd11679);
    write_cfg(REG_TAP3, 16'h0000);

    // widest row (masked and clamped) left part way, then an oversized height cut short
    set_frame(16'hFFFF, 16'd5);
    steady = 1'b1;
    for (int k = 0; k < 40; k++) push_pixel(8'($urandom_range(0, 255)));
    drain();
    set_frame(16'd5, 16'h1FFF);
    for (int k = 0; k < 60; k++) push_pixel(8'($urandom_range(0, 255)));
    steady = 1'b0;
    drain();
    write_cfg(REG_HEIGHT, 16'd5);

    // random frames
    begin
      int start;
      start = n_pixels;
      while (n_pixels - start < 260) begin
        if ($urandom_range(0, 5) == 0)
          set_frame(16'($urandom_range(0, 4)), 16'($urandom_range(0, 8)));
        else
          set_frame(16'($urandom_range(5, 12)), 16'($urandom_range(5, 8)));
        if ($urandom_range(0, 3) == 0) begin
          write_cfg(REG_TAP0, 16'($urandom_range(0, 65535)));
          write_cfg(REG_TAP1, 16'($urandom_range(0, 65535)));
          write_cfg(REG_TAP2, 16'($urandom_range(0, 65535)));
        end else begin
          write_cfg(REG_TAP0, 16'($urandom_range(8000, 20000)));
          write_cfg(REG_TAP1, 16'($urandom_range(6000, 16000)));
          write_cfg(REG_TAP2, 16'($urandom_range(0, 12000)));
        end
        write_cfg(REG_TAP3, 16'($urandom_range(0, 65535)));
        steady = ($urandom_range(0, 7) == 0);
        send_frame(0);
        steady = 1'b0;
      end
    end

    $display("covered %0d pixels in %0d frames, %0d results checked", n_pixels, n_frames,
             sb.n_results);
    $display("clamped and masked frame sizes, size changes mid-frame, zero and saturating weights");
    if (errors == 0 && sb.pending.size() == 0)
      $display("gaussian_blur_5x5_core verification clean");
    else
      $display("gaussian_blur_5x5_core verification failed");
    $finish;
  end
endmodule
